>>> src/pbsa_pkg.sv
// Shared types, constants and helpers for the profile bin symbol attribution block.
`default_nettype none
package pbsa_pkg;

  localparam int MAX_SYMBOLS = 1024;
  localparam int SHARE_SCALE = 100;

  localparam int IDX_W   = $clog2(MAX_SYMBOLS);
  localparam int CNT_W   = $clog2(MAX_SYMBOLS + 1);
  localparam int ADDR_W  = 16;
  localparam int SPAN_W  = ADDR_W + 1;
  localparam int ACC_W   = 48;
  localparam int CALL_W  = 31;
  localparam int TICK_W  = 15;
  localparam int REQ_W   = 3;
  localparam int SIDX_W  = 10;
  localparam int STAT_W  = 2;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W   = 16;

  // widest overlap times scale, and the full rounded dividend
  localparam longint PROD_MAX = longint'(SHARE_SCALE) * (longint'(1) << ADDR_W);
  localparam int     PROD_W   = $clog2(PROD_MAX + 1);
  localparam longint DIVD_MAX = PROD_MAX * ((longint'(1) << TICK_W) - 1)
                                + (longint'(1) << (ADDR_W - 1));
  localparam int     DIVD_W   = $clog2(DIVD_MAX + 1);
  localparam int     DCNT_W   = $clog2(DIVD_W + 1);

  localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};

  typedef enum logic [REQ_W-1:0] {
    REQ_LOAD  = 3'd0,
    REQ_CALL  = 3'd1,
    REQ_BIN   = 3'd2,
    REQ_READ  = 3'd3,
    REQ_BEGIN = 3'd4
  } req_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2,
    ST_NOSYM = 2'd3
  } stat_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOW_PC     = 1'b0,
    CFG_HALF_SCALE = 1'b1
  } cfg_t;

  typedef enum logic [4:0] {
    OP_IDLE, OP_LATCH, OP_DISPATCH, OP_LOAD,
    OP_CALL_RD, OP_CALL_STEP, OP_CALL_RDC, OP_CALL_UPD,
    OP_BIN_STEP, OP_BIN_RD0, OP_BIN_FIRST, OP_NXT_RD, OP_SKIP_STEP, OP_NXT_LATCH,
    OP_OV, OP_MUL, OP_DIV_START, OP_ACC,
    OP_SYM_RD, OP_SYM_CAP, OP_BEG_START, OP_BEG_FIN, OP_OUT_LOAD
  } op_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DISPATCH, S_LOAD,
    S_CALL_RD, S_CALL_CMP, S_CALL_UPD,
    S_BIN_STEP, S_BIN_CHK, S_BIN_FIRST, S_SKIP_RD, S_SKIP_CMP,
    S_OV, S_MUL, S_DIV_START, S_DIV_WAIT, S_ACC, S_WALK_RD, S_WALK_LAT,
    S_SYM_RD, S_SYM_CAP, S_BEG_START, S_BEG_WAIT, S_BEG_FIN, S_DONE
  } state_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    req_t req;
    logic no_syms;
    logic full;
    logic idx_bad;
    logic call_more;
    logic bin_idle;
    logic first_miss;
    logic skip_more;
    logic walk_end;
    logic div_busy;
  } st_t;

  function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] a,
                                               input logic [ACC_W-1:0] b);
    logic [ACC_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[ACC_W] ? ACC_MAX : s[ACC_W-1:0];
  endfunction

endpackage
`default_nettype wire

>>> src/pbsa_req_if.sv
// Request channel: one item per accepted valid/ready handshake.
`default_nettype none
interface pbsa_req_if;
  import pbsa_pkg::*;
  logic                valid;
  logic                ready;
  logic [REQ_W-1:0]    req_type;
  logic [ADDR_W-1:0]   address;
  logic [CALL_W-1:0]   call_count;
  logic [TICK_W-1:0]   bin_ticks;
  logic [SIDX_W-1:0]   symbol_index;

  modport source (output valid, req_type, address, call_count, bin_ticks, symbol_index,
                  input ready);
  modport sink   (input valid, req_type, address, call_count, bin_ticks, symbol_index,
                  output ready);
endinterface
`default_nettype wire

>>> src/pbsa_rsp_if.sv
// Response channel: one result item per request item.
`default_nettype none
interface pbsa_rsp_if;
  import pbsa_pkg::*;
  logic               valid;
  logic               ready;
  logic [STAT_W-1:0]  status;
  logic [ACC_W-1:0]   sample_share;
  logic [ACC_W-1:0]   calls_total;
  logic [ACC_W-1:0]   all_ticks;
  logic [ACC_W-1:0]   all_calls;
  logic [CNT_W-1:0]   symbols_loaded;

  modport source (output valid, status, sample_share, calls_total, all_ticks, all_calls,
                  symbols_loaded, input ready);
  modport sink   (input valid, status, sample_share, calls_total, all_ticks, all_calls,
                  symbols_loaded, output ready);
endinterface
`default_nettype wire

>>> src/pbsa_div.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module pbsa_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [pbsa_pkg::DIVD_W-1:0]   dividend,
  input  logic [pbsa_pkg::SPAN_W-1:0]   divisor,
  output logic                          busy,
  output logic [pbsa_pkg::DIVD_W-1:0]   quotient,
  output logic [pbsa_pkg::SPAN_W-1:0]   remainder
);
  import pbsa_pkg::*;

  logic [DCNT_W-1:0] count;
  logic [DIVD_W-1:0] quo;
  logic [SPAN_W-1:0] rem;
  logic [SPAN_W-1:0] dvs;
  logic [SPAN_W:0]   trial;
  logic              fits;

  assign trial = {rem, quo[DIVD_W-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (start) begin
      count <= DCNT_W'(DIVD_W);
    end else if (count != '0) begin
      count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (count != '0) begin
      quo <= {quo[DIVD_W-2:0], fits};
      rem <= fits ? SPAN_W'(trial - {1'b0, dvs}) : trial[SPAN_W-1:0];
    end
  end

  assign busy      = count != '0;
  assign quotient  = quo;
  assign remainder = rem;
endmodule
`default_nettype wire

>>> src/pbsa_dp.sv
// Datapath: symbol tables, bin cursor, accumulators, shared divider and result register.
`default_nettype none
module pbsa_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [pbsa_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pbsa_pkg::CFG_W-1:0]        cfg_data,
  input  logic [pbsa_pkg::REQ_W-1:0]        in_req_type,
  input  logic [pbsa_pkg::ADDR_W-1:0]       in_address,
  input  logic [pbsa_pkg::CALL_W-1:0]       in_call_count,
  input  logic [pbsa_pkg::TICK_W-1:0]       in_bin_ticks,
  input  logic [pbsa_pkg::SIDX_W-1:0]       in_symbol_index,
  input  pbsa_pkg::cmd_t                    cmd,
  output pbsa_pkg::st_t                     st,
  output logic [pbsa_pkg::STAT_W-1:0]       out_status,
  output logic [pbsa_pkg::ACC_W-1:0]        out_sample_share,
  output logic [pbsa_pkg::ACC_W-1:0]        out_calls_total,
  output logic [pbsa_pkg::ACC_W-1:0]        out_all_ticks,
  output logic [pbsa_pkg::ACC_W-1:0]        out_all_calls,
  output logic [pbsa_pkg::CNT_W-1:0]        out_symbols_loaded
);
  import pbsa_pkg::*;

  // configuration
  logic [ADDR_W-1:0] low_pc, half_scale;
  // latched item
  req_t              req_r;
  logic [ADDR_W-1:0] addr_r;
  logic [CALL_W-1:0] calls_r;
  logic [TICK_W-1:0] ticks_r;
  logic [SIDX_W-1:0] idx_r;
  // architectural state
  logic [CNT_W-1:0]  total;
  logic [ADDR_W-1:0] bin_upper;
  logic [SPAN_W-1:0] bin_fraction, bin_step, bin_step_fraction;
  logic [IDX_W-1:0]  cursor;
  logic [ACC_W-1:0]  tick_sum, call_sum;
  // walk registers
  logic [CNT_W-1:0]  j, nxt;
  logic [IDX_W-1:0]  cur;
  logic [ADDR_W-1:0] scur, snxt, low_r;
  logic [SPAN_W-1:0] high_r, binlen;
  logic [PROD_W-1:0] prod;
  logic [DIVD_W-1:0] divd;
  stat_t             res_status;
  logic [ACC_W-1:0]  res_share, res_ctot;

  // memories
  logic [ADDR_W-1:0] start_mem   [MAX_SYMBOLS];
  logic [ACC_W-1:0]  samples_mem [MAX_SYMBOLS];
  logic [ACC_W-1:0]  calls_mem   [MAX_SYMBOLS];
  logic [ADDR_W-1:0] start_rdata;
  logic [ACC_W-1:0]  samples_rdata, calls_rdata;
  logic              start_re, samples_re, calls_re;
  logic              samples_we, calls_we;
  logic [IDX_W-1:0]  start_raddr, samples_addr, calls_addr;
  logic [ACC_W-1:0]  samples_wdata, calls_wdata;

  // divider
  logic              div_start, div_busy;
  logic [DIVD_W-1:0] div_dividend, div_q;
  logic [SPAN_W-1:0] div_divisor, div_r;

  // combinational helpers
  logic [SPAN_W-1:0] sc, high_sum, frac_sum, high_adj, frac_new;
  logic              frac_over;
  logic [SPAN_W-1:0] ov_end, ov_beg, ov;
  logic [IDX_W-1:0]  jm1;
  logic [SPAN_W-1:0] beg_q, beg_r;

  assign sc        = (half_scale == '0) ? SPAN_W'(1) : {1'b0, half_scale};
  assign high_sum  = {1'b0, bin_upper} + bin_step;
  assign frac_sum  = bin_fraction + bin_step_fraction;
  assign frac_over = frac_sum >= sc;
  assign high_adj  = (frac_over && high_sum > {1'b0, bin_upper}) ? high_sum - 1'b1 : high_sum;
  assign frac_new  = frac_over ? frac_sum - sc : frac_sum;

  assign ov_end = (nxt < total && {1'b0, snxt} < high_r) ? {1'b0, snxt} : high_r;
  assign ov_beg = (scur > low_r) ? {1'b0, scur} : {1'b0, low_r};
  assign ov     = (ov_end > ov_beg) ? ov_end - ov_beg : '0;

  assign jm1   = IDX_W'(j - 1'b1);
  assign beg_q = (div_r != '0) ? div_q[SPAN_W-1:0] + 1'b1 : div_q[SPAN_W-1:0];
  assign beg_r = (div_r != '0) ? sc - div_r : '0;

  // memory port selection
  always_comb begin
    start_re      = 1'b0;
    start_raddr   = nxt[IDX_W-1:0];
    samples_re    = 1'b0;
    samples_we    = 1'b0;
    samples_addr  = cur;
    samples_wdata = '0;
    calls_re      = 1'b0;
    calls_we      = 1'b0;
    calls_addr    = jm1;
    calls_wdata   = '0;
    unique case (cmd.op)
      OP_LOAD: begin
        samples_we   = 1'b1;
        samples_addr = total[IDX_W-1:0];
        calls_we     = 1'b1;
        calls_addr   = total[IDX_W-1:0];
      end
      OP_CALL_RD: begin
        start_re    = 1'b1;
        start_raddr = j[IDX_W-1:0];
      end
      OP_CALL_RDC: calls_re = 1'b1;
      OP_CALL_UPD: begin
        calls_we    = 1'b1;
        calls_wdata = sat_add(calls_rdata, ACC_W'(calls_r));
      end
      OP_BIN_RD0: begin
        start_re    = 1'b1;
        start_raddr = cursor;
      end
      OP_NXT_RD:    start_re   = 1'b1;
      OP_DIV_START: samples_re = 1'b1;
      OP_ACC: begin
        samples_we    = 1'b1;
        samples_wdata = sat_add(samples_rdata, ACC_W'(div_q));
      end
      OP_SYM_RD: begin
        samples_re   = 1'b1;
        samples_addr = IDX_W'(idx_r);
        calls_re     = 1'b1;
        calls_addr   = IDX_W'(idx_r);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD) start_mem[total[IDX_W-1:0]] <= addr_r;
    if (start_re) start_rdata <= start_mem[start_raddr];
  end

  always_ff @(posedge clk) begin
    if (samples_we) samples_mem[samples_addr] <= samples_wdata;
    if (samples_re) samples_rdata <= samples_mem[samples_addr];
  end

  always_ff @(posedge clk) begin
    if (calls_we) calls_mem[calls_addr] <= calls_wdata;
    if (calls_re) calls_rdata <= calls_mem[calls_addr];
  end

  assign div_start    = cmd.op == OP_DIV_START || cmd.op == OP_BEG_START;
  assign div_dividend = (cmd.op == OP_BEG_START) ? DIVD_W'(1 << ADDR_W) : divd;
  assign div_divisor  = (cmd.op == OP_BEG_START) ? sc : binlen;

  pbsa_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .busy      (div_busy),
    .quotient  (div_q),
    .remainder (div_r)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      low_pc     <= '0;
      half_scale <= ADDR_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_t'(cfg_index))
        CFG_LOW_PC:     low_pc     <= cfg_data;
        CFG_HALF_SCALE: half_scale <= cfg_data;
        default: ;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      total             <= '0;
      bin_upper         <= '0;
      bin_fraction      <= '0;
      bin_step          <= '0;
      bin_step_fraction <= '0;
      cursor            <= '0;
      tick_sum          <= '0;
      call_sum          <= '0;
    end else begin
      unique case (cmd.op)
        OP_LOAD:     total    <= total + 1'b1;
        OP_CALL_UPD: call_sum <= sat_add(call_sum, ACC_W'(calls_r));
        OP_BIN_STEP: begin
          bin_fraction <= frac_new;
          bin_upper    <= high_adj[ADDR_W-1:0];
          if (ticks_r != '0) tick_sum <= sat_add(tick_sum, ACC_W'(ticks_r));
        end
        OP_ACC:      cursor <= cur;
        OP_BEG_FIN: begin
          bin_step          <= beg_q;
          bin_step_fraction <= beg_r;
          bin_upper         <= low_pc;
          bin_fraction      <= '0;
          cursor            <= '0;
        end
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LATCH: begin
        req_r     <= req_t'(in_req_type);
        addr_r    <= in_address;
        calls_r   <= in_call_count;
        ticks_r   <= in_bin_ticks;
        idx_r     <= in_symbol_index;
        j         <= CNT_W'(1);
        res_share <= '0;
        res_ctot  <= '0;
      end
      OP_DISPATCH: begin
        unique case (req_r)
          REQ_LOAD: res_status <= (total >= CNT_W'(MAX_SYMBOLS)) ? ST_FULL : ST_OK;
          REQ_CALL, REQ_BIN: res_status <= (total == '0) ? ST_NOSYM : ST_OK;
          REQ_READ: res_status <= (total == '0) ? ST_NOSYM :
                                  (CNT_W'(idx_r) >= total) ? ST_RANGE : ST_OK;
          default: res_status <= ST_OK;
        endcase
      end
      OP_CALL_STEP: j <= j + 1'b1;
      OP_BIN_STEP: begin
        low_r  <= bin_upper;
        high_r <= high_adj;
        binlen <= high_adj - {1'b0, bin_upper};
      end
      OP_BIN_FIRST: begin
        cur  <= cursor;
        scur <= start_rdata;
        nxt  <= CNT_W'(cursor) + 1'b1;
      end
      OP_SKIP_STEP: begin
        cur  <= nxt[IDX_W-1:0];
        scur <= start_rdata;
        nxt  <= nxt + 1'b1;
      end
      OP_NXT_LATCH: snxt <= start_rdata;
      OP_OV:  prod <= PROD_W'(PROD_W'(SHARE_SCALE) * PROD_W'(ov));
      OP_MUL: divd <= DIVD_W'(prod) * DIVD_W'(ticks_r) + DIVD_W'(binlen >> 1);
      OP_ACC: begin
        // advance to the next overlapping symbol
        cur  <= nxt[IDX_W-1:0];
        scur <= snxt;
        nxt  <= nxt + 1'b1;
      end
      OP_SYM_CAP: begin
        res_share <= samples_rdata;
        res_ctot  <= calls_rdata;
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.op == OP_OUT_LOAD) begin
      out_status         <= res_status;
      out_sample_share   <= res_share;
      out_calls_total    <= res_ctot;
      out_all_ticks      <= tick_sum;
      out_all_calls      <= call_sum;
      out_symbols_loaded <= total;
    end
  end

  always_comb begin
    st.req        = req_r;
    st.no_syms    = total == '0;
    st.full       = total >= CNT_W'(MAX_SYMBOLS);
    st.idx_bad    = CNT_W'(idx_r) >= total;
    st.call_more  = j < total && start_rdata <= addr_r;
    st.bin_idle   = ticks_r == '0 || binlen == '0 || CNT_W'(cursor) >= total;
    st.first_miss = {1'b0, start_rdata} >= high_r;
    st.skip_more  = nxt < total && start_rdata <= low_r;
    st.walk_end   = nxt >= total || {1'b0, snxt} >= high_r;
    st.div_busy   = div_busy;
  end
endmodule
`default_nettype wire

>>> src/pbsa_ctrl.sv
// Controller: sequences each item through the datapath and owns the handshakes.
`default_nettype none
module pbsa_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  pbsa_pkg::st_t   st,
  output pbsa_pkg::cmd_t  cmd
);
  import pbsa_pkg::*;

  state_t state, state_next;
  logic   out_free;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst)                        out_valid <= 1'b0;
    else if (cmd.op == OP_OUT_LOAD) out_valid <= 1'b1;
    else if (out_ready)             out_valid <= 1'b0;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:     if (in_valid) state_next = S_DISPATCH;
      S_DISPATCH: begin
        unique case (st.req)
          REQ_LOAD:  state_next = st.full ? S_DONE : S_LOAD;
          REQ_CALL:  state_next = st.no_syms ? S_DONE : S_CALL_RD;
          REQ_BIN:   state_next = S_BIN_STEP;
          REQ_READ:  state_next = (st.no_syms || st.idx_bad) ? S_DONE : S_SYM_RD;
          REQ_BEGIN: state_next = S_BEG_START;
          default:   state_next = S_DONE;
        endcase
      end
      S_LOAD:      state_next = S_DONE;
      S_CALL_RD:   state_next = S_CALL_CMP;
      S_CALL_CMP:  state_next = st.call_more ? S_CALL_RD : S_CALL_UPD;
      S_CALL_UPD:  state_next = S_DONE;
      S_BIN_STEP:  state_next = S_BIN_CHK;
      S_BIN_CHK:   state_next = st.bin_idle ? S_DONE : S_BIN_FIRST;
      S_BIN_FIRST: state_next = st.first_miss ? S_DONE : S_SKIP_RD;
      S_SKIP_RD:   state_next = S_SKIP_CMP;
      S_SKIP_CMP:  state_next = st.skip_more ? S_SKIP_RD : S_OV;
      S_OV:        state_next = S_MUL;
      S_MUL:       state_next = S_DIV_START;
      S_DIV_START: state_next = S_DIV_WAIT;
      S_DIV_WAIT:  if (!st.div_busy) state_next = S_ACC;
      S_ACC:       state_next = st.walk_end ? S_DONE : S_WALK_RD;
      S_WALK_RD:   state_next = S_WALK_LAT;
      S_WALK_LAT:  state_next = S_OV;
      S_SYM_RD:    state_next = S_SYM_CAP;
      S_SYM_CAP:   state_next = S_DONE;
      S_BEG_START: state_next = S_BEG_WAIT;
      S_BEG_WAIT:  if (!st.div_busy) state_next = S_BEG_FIN;
      S_BEG_FIN:   state_next = S_DONE;
      S_DONE:      if (out_free) state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd.op   = OP_IDLE;
    in_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd.op = OP_LATCH;
      end
      S_DISPATCH:  cmd.op = OP_DISPATCH;
      S_LOAD:      cmd.op = OP_LOAD;
      S_CALL_RD:   cmd.op = OP_CALL_RD;
      S_CALL_CMP:  cmd.op = st.call_more ? OP_CALL_STEP : OP_CALL_RDC;
      S_CALL_UPD:  cmd.op = OP_CALL_UPD;
      S_BIN_STEP:  cmd.op = OP_BIN_STEP;
      S_BIN_CHK:   if (!st.bin_idle) cmd.op = OP_BIN_RD0;
      S_BIN_FIRST: if (!st.first_miss) cmd.op = OP_BIN_FIRST;
      S_SKIP_RD:   cmd.op = OP_NXT_RD;
      S_SKIP_CMP:  cmd.op = st.skip_more ? OP_SKIP_STEP : OP_NXT_LATCH;
      S_OV:        cmd.op = OP_OV;
      S_MUL:       cmd.op = OP_MUL;
      S_DIV_START: cmd.op = OP_DIV_START;
      S_ACC:       cmd.op = OP_ACC;
      S_WALK_RD:   cmd.op = OP_NXT_RD;
      S_WALK_LAT:  cmd.op = OP_NXT_LATCH;
      S_SYM_RD:    cmd.op = OP_SYM_RD;
      S_SYM_CAP:   cmd.op = OP_SYM_CAP;
      S_BEG_START: cmd.op = OP_BEG_START;
      S_BEG_FIN:   cmd.op = OP_BEG_FIN;
      S_DONE:      if (out_free) cmd.op = OP_OUT_LOAD;
      default: ;
    endcase
  end
endmodule
`default_nettype wire

>>> src/profile_bin_symbol_attribution_top.sv
// Top level of the profile bin symbol attribution block.
//
//   channel  dir  handshake              payload
//   req      in   req.valid/req.ready    req_type address call_count bin_ticks symbol_index
//   rsp      out  rsp.valid/rsp.ready    status sample_share calls_total all_ticks
//                                        all_calls symbols_loaded
//   cfg      in   cfg_we                 cfg_index cfg_data
//
// One item at a time. A call record reads the start table once per entry it walks. Begin takes
// one pass of the shared divider; a bin that credits nothing skips the divider, else it
// takes one divider pass per overlapping symbol plus a start-table read per symbol skipped.
// Synchronous reset clears the counters; the symbol tables need no clearing pass since
// entries past the fill count are never used.
// A new item is taken while the previous result waits in the output register.
`default_nettype none
module profile_bin_symbol_attribution_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [pbsa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pbsa_pkg::CFG_W-1:0]      cfg_data,
  pbsa_req_if.sink                        req,
  pbsa_rsp_if.source                      rsp
);
  import pbsa_pkg::*;

  cmd_t cmd;
  st_t  st;

  pbsa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .st        (st),
    .cmd       (cmd)
  );

  pbsa_dp u_dp (
    .clk                (clk),
    .rst                (rst),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_req_type        (req.req_type),
    .in_address         (req.address),
    .in_call_count      (req.call_count),
    .in_bin_ticks       (req.bin_ticks),
    .in_symbol_index    (req.symbol_index),
    .cmd                (cmd),
    .st                 (st),
    .out_status         (rsp.status),
    .out_sample_share   (rsp.sample_share),
    .out_calls_total    (rsp.calls_total),
    .out_all_ticks      (rsp.all_ticks),
    .out_all_calls      (rsp.all_calls),
    .out_symbols_loaded (rsp.symbols_loaded)
  );

`ifndef NO_ASSERTIONS
  a_loaded_bound: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> rsp.symbols_loaded <= CNT_W'(MAX_SYMBOLS))
    else $error("symbol count above table size");

  a_div_idle_start: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_DIV_START || cmd.op == OP_BEG_START) |-> !st.div_busy)
    else $error("divider started while busy");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status != ST_OK) |-> (rsp.sample_share == '0 && rsp.calls_total == '0))
    else $error("failed item carries totals");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_OUT_LOAD |-> (!rsp.valid || rsp.ready))
    else $error("result overwritten before taken");
`endif
endmodule
`default_nettype wire
